/* rtl/cpio_pkg.sv */
`default_nettype none
package cpio_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_NAME    = 3'd2,
    PH_NAMEPAD = 3'd3,
    PH_DATA    = 3'd4,
    PH_DATAPAD = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_NAME  = 3'd0,
    K_ENTRY = 3'd1,
    K_END   = 3'd2,
    K_DATA  = 3'd3,
    K_ERROR = 3'd4
  } kind_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OLD  = 2'd1;
  localparam logic [1:0] ERR_BAD  = 2'd2;

  localparam int unsigned OUT_W = 3 + 8 + 1 + 4 * 32 + 2;  // 142

  // One result item; packs to tdata with kind in the lowest bits
  typedef struct packed {
    logic [1:0]  error_code;
    logic [31:0] name_size;
    logic [31:0] data_size;
    logic [31:0] mod_time;
    logic [31:0] file_mode;
    logic        is_last;
    logic [7:0]  byte_value;
    logic [2:0]  kind;
  } result_t;

  // Work handed from the front to the back: up to two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } job_t;

  localparam logic [7:0] TRAILER_TEXT [10] = '{8'h54, 8'h52, 8'h41, 8'h49, 8'h4c,
                                              8'h45, 8'h52, 8'h21, 8'h21, 8'h21};
  localparam logic [7:0] MAGIC_ASCII [6] = '{8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31};
  localparam logic [7:0] MAGIC_OLD  [6] = '{8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h37};
  localparam logic [6:0] HEADER_BYTES = 7'd104;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] d;
    d = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) d = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      d = {1'b0, b[3:0] + 4'd9};
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/cpio_front.sv */
`default_nettype none
module cpio_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_vld,
  input  wire logic [7:0]    byte_in,
  output logic               byte_rdy,
  output logic               job_vld,
  output cpio_pkg::job_t     job,
  input  wire logic          job_rdy
);
  import cpio_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  hcnt_r, hcnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        stop_r, stop_nxt;
  logic [1:0]  mflag_r, mflag_nxt;
  logic [31:0] mode_r, mode_nxt, mtime_r, mtime_nxt, size_r, size_nxt, nsize_r, nsize_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [3:0]  tidx_r, tidx_nxt;
  logic        tbad_r, tbad_nxt, tend_r, tend_nxt;
  logic        out_vld_r;
  job_t        job_r, job_nxt;
  logic        emit;
  logic        take;

  assign byte_rdy = !out_vld_r || job_rdy;
  assign take     = byte_vld && byte_rdy;
  assign job_vld  = out_vld_r;
  assign job      = job_r;

  // Byte classification and state update
  always_comb begin
    logic [2:0]  mi;
    logic [2:0]  dpos;
    logic [4:0]  d;
    logic [31:0] racc;
    logic [1:0]  mf;
    logic [31:0] rm;
    logic        eos;
    result_t     rec;
    phase_nxt = phase_r; hcnt_nxt = hcnt_r; acc_nxt = acc_r; stop_nxt = stop_r;
    mflag_nxt = mflag_r; mode_nxt = mode_r; mtime_nxt = mtime_r; size_nxt = size_r;
    nsize_nxt = nsize_r; rem_nxt = rem_r; pos_nxt = pos_r; tidx_nxt = tidx_r;
    tbad_nxt = tbad_r; tend_nxt = tend_r;
    job_nxt = '0; emit = 1'b0;
    mi = 3'd0; dpos = 3'd0; d = 5'd0; racc = 32'd0; mf = 2'd0; rm = 32'd0;
    rec = '0; rec.kind = K_ENTRY;
    eos = (pos_r == 2'd3);  // next position wraps to zero
    if (phase_r != PH_DONE) pos_nxt = pos_r + 2'd1;
    case (phase_r)
      PH_MAGIC: begin
        mi = (hcnt_r < 7'd6) ? hcnt_r[2:0] : 3'd0;
        mf = mflag_r;
        if (byte_in != MAGIC_ASCII[mi]) mf[0] = 1'b0;
        if (byte_in != MAGIC_OLD[mi])  mf[1] = 1'b0;
        mflag_nxt = mf;
        hcnt_nxt = {4'd0, mi} + 7'd1;
        if (mi == 3'd5) begin
          if (mf[1]) begin
            emit = 1'b1; job_nxt.r0.kind = K_ERROR; job_nxt.r0.error_code = ERR_OLD;
            phase_nxt = PH_DONE;
          end else if (!mf[0]) begin
            emit = 1'b1; job_nxt.r0.kind = K_ERROR; job_nxt.r0.error_code = ERR_BAD;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_HEADER; hcnt_nxt = 7'd0;
          end
        end
      end
      PH_HEADER: begin
        dpos = hcnt_r[2:0];
        racc = (dpos == 3'd0) ? 32'd0 : acc_r;
        stop_nxt = (dpos == 3'd0) ? 1'b0 : stop_r;
        acc_nxt = racc;
        if (!stop_nxt) begin
          d = hex_digit(byte_in);
          if (d[4]) stop_nxt = 1'b1;
          else acc_nxt = {racc[27:0], d[3:0]};
        end
        if (dpos == 3'd7) begin
          case (hcnt_r[6:3])
            4'd1:  mode_nxt  = acc_nxt;
            4'd5:  mtime_nxt = acc_nxt;
            4'd6:  size_nxt  = acc_nxt;
            4'd11: nsize_nxt = acc_nxt;
            default: ;
          endcase
        end
        hcnt_nxt = hcnt_r + 7'd1;
        if (hcnt_nxt >= HEADER_BYTES) begin
          tidx_nxt = 4'd0; tbad_nxt = 1'b0; tend_nxt = 1'b0;
          if (nsize_nxt == 32'd0) begin
            emit = 1'b1;
            rec.file_mode = mode_nxt; rec.mod_time = mtime_nxt;
            rec.data_size = size_nxt; rec.name_size = nsize_nxt;
            job_nxt.r0 = rec;
            if (!eos) phase_nxt = PH_NAMEPAD;
            else if (size_nxt == 32'd0) begin
              phase_nxt = PH_MAGIC; hcnt_nxt = 7'd0; mflag_nxt = 2'b11;
            end else begin
              rem_nxt = size_nxt; phase_nxt = PH_DATA;
            end
          end else begin
            rem_nxt = nsize_nxt; phase_nxt = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (!tbad_r && !tend_r) begin
          if (byte_in == 8'd0) begin
            tend_nxt = 1'b1;
            if (tidx_r != 4'd10) tbad_nxt = 1'b1;
          end else if (tidx_r < 4'd10 && byte_in == TRAILER_TEXT[tidx_r]) begin
            tidx_nxt = tidx_r + 4'd1;
          end else tbad_nxt = 1'b1;
        end
        rm = rem_r - 32'd1;
        rem_nxt = rm;
        emit = 1'b1;
        job_nxt.r0.kind = K_NAME; job_nxt.r0.byte_value = byte_in;
        job_nxt.r0.is_last = (rm == 32'd0);
        if (rm == 32'd0) begin
          job_nxt.two = 1'b1;
          if (!tbad_nxt && tidx_nxt == 4'd10) begin
            job_nxt.r1.kind = K_END; phase_nxt = PH_DONE;
          end else begin
            rec.file_mode = mode_r; rec.mod_time = mtime_r;
            rec.data_size = size_r; rec.name_size = nsize_r;
            job_nxt.r1 = rec;
            if (!eos) phase_nxt = PH_NAMEPAD;
            else if (size_r == 32'd0) begin
              phase_nxt = PH_MAGIC; hcnt_nxt = 7'd0; mflag_nxt = 2'b11;
            end else begin
              rem_nxt = size_r; phase_nxt = PH_DATA;
            end
          end
        end
      end
      PH_NAMEPAD: begin
        if (eos) begin
          if (size_r == 32'd0) begin
            phase_nxt = PH_MAGIC; hcnt_nxt = 7'd0; mflag_nxt = 2'b11;
          end else begin
            rem_nxt = size_r; phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        rm = rem_r - 32'd1;
        rem_nxt = rm;
        emit = 1'b1;
        job_nxt.r0.kind = K_DATA; job_nxt.r0.byte_value = byte_in;
        job_nxt.r0.is_last = (rm == 32'd0);
        if (rm == 32'd0) begin
          if (eos) begin
            phase_nxt = PH_MAGIC; hcnt_nxt = 7'd0; mflag_nxt = 2'b11;
          end else phase_nxt = PH_DATAPAD;
        end
      end
      PH_DATAPAD: begin
        if (eos) begin
          phase_nxt = PH_MAGIC; hcnt_nxt = 7'd0; mflag_nxt = 2'b11;
        end
      end
      default: phase_nxt = PH_DONE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC; hcnt_r <= '0; acc_r <= '0; stop_r <= 1'b0;
      mflag_r <= 2'b11; mode_r <= '0; mtime_r <= '0; size_r <= '0; nsize_r <= '0;
      rem_r <= '0; pos_r <= '0; tidx_r <= '0; tbad_r <= 1'b0; tend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; hcnt_r <= hcnt_nxt; acc_r <= acc_nxt; stop_r <= stop_nxt;
        mflag_r <= mflag_nxt; mode_r <= mode_nxt; mtime_r <= mtime_nxt;
        size_r <= size_nxt; nsize_r <= nsize_nxt; rem_r <= rem_nxt; pos_r <= pos_nxt;
        tidx_r <= tidx_nxt; tbad_r <= tbad_nxt; tend_r <= tend_nxt;
      end
      if (byte_rdy) out_vld_r <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_rdy) job_r <= job_nxt;
  end

  // Nothing leaves after the archive is finished
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(phase_r == PH_DONE) && $past(take) |-> !out_vld_r)
    else $error("front emitted work after done");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !job_rdy |=> out_vld_r && $stable(job_r))
    else $error("stalled job changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MAGIC |-> hcnt_r <= 7'd6)
    else $error("magic count out of range");

endmodule
`default_nettype wire

/* rtl/cpio_back.sv */
`default_nettype none
module cpio_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  job_vld,
  input  wire cpio_pkg::job_t        job,
  output logic                       job_rdy,
  output logic                       out_vld,
  output cpio_pkg::result_t          out_res,
  input  wire logic                  out_rdy
);
  import cpio_pkg::*;

  // Two-entry result queue: every job fits in one free queue
  result_t     q_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rd_r;
  logic        pop, push;

  assign out_vld = cnt_r != 2'd0;
  assign out_res = q_r[rd_r];
  assign pop     = out_vld && out_rdy;
  // Room after this cycle's pop must cover one or two new entries
  assign job_rdy = (cnt_r == 2'd0) || (pop && (cnt_r == 2'd1 || !job.two))
                   || (cnt_r == 2'd1 && !job.two);
  assign push    = job_vld && job_rdy;

  always_comb begin
    cnt_nxt = cnt_r - {1'b0, pop} + (push ? (job.two ? 2'd2 : 2'd1) : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) rd_r <= ~rd_r;
    end
  end

  // Write slots after the surviving entries
  always_ff @(posedge clk) begin
    logic       wp;
    wp = rd_r ^ pop ^ (cnt_r - {1'b0, pop} == 2'd1);
    if (push) begin
      q_r[wp] <= job.r0;
      if (job.two) q_r[~wp] <= job.r1;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_rdy |=> out_vld && $stable(out_res))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    push && job.two |-> cnt_r - {1'b0, pop} == 2'd0)
    else $error("pair pushed without room");

endmodule
`default_nettype wire

/* rtl/cpio_newc_stream_parser_unit.sv */
`default_nettype none
// cpio newc archive parser.
// in_*: one archive byte per item (tdata[7:0]).
// out_*: result items: name bytes, entry records, end mark, data bytes, errors.
//   tdata packs kind, byte_value, is_last, file_mode, mod_time, data_size,
//   name_size, error_code from the lowest bit up (142 bits padded to 144).
// Throughput: one byte per cycle while the output drains; an entry's last name
// byte yields two results and waits until the result queue has room for both.
// A byte's results pass through the front register, then the two-entry result
// queue, before they appear on the output.
// Reset (rst_n low, synchronous) returns to magic checking with all fields
// zero and empties the queue. When out_tready is low the queue fills, the
// front holds its job and in_tready falls; nothing is dropped.
// After the trailer or an error every further byte is taken and ignored.
module cpio_newc_stream_parser_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // in_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata   // kind, byte_value, is_last, file_mode,
                                        // mod_time, data_size, name_size, error_code
);
  import cpio_pkg::*;

  logic    job_vld, job_rdy;
  job_t    job;
  result_t res;

  cpio_front u_front (
    .clk, .rst_n, .byte_vld(in_tvalid), .byte_in(in_tdata), .byte_rdy(in_tready),
    .job_vld, .job, .job_rdy
  );

  cpio_back u_back (
    .clk, .rst_n, .job_vld, .job, .job_rdy,
    .out_vld(out_tvalid), .out_res(res), .out_rdy(out_tready)
  );

  assign out_tdata = {2'b00, res};

endmodule
`default_nettype wire
